@@ src/mp4bdr_pkg.sv @@
// shared types and constants of the mp4 box deframer and router
`timescale 1ns / 1ps

package mp4bdr_pkg;

   localparam int unsigned HEADER_BYTES = 16;
   localparam int unsigned SHORT_HDR    = 8;
   localparam int unsigned HDR_IDX_W    = $clog2(HEADER_BYTES);
   localparam int unsigned MAX_W        = 41;
   localparam logic [MAX_W-1:0] MAX_SIZE_RESET = 41'd67108864;

   localparam logic [31:0] TYPE_MOOF = 32'h6D6F6F66;
   localparam logic [31:0] TYPE_MDAT = 32'h6D646174;
   localparam logic [31:0] SIZE_EXTENDED = 32'd1;

   localparam int unsigned Q_DEPTH = 2;
   localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
   localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic FUNC_BYTE    = 1'b0;
   localparam logic FUNC_RESTART = 1'b1;

   localparam logic [1:0] ROUTE_INIT  = 2'd0;
   localparam logic [1:0] ROUTE_FRAG  = 2'd1;
   localparam logic [1:0] ROUTE_DROP  = 2'd2;
   localparam logic [1:0] ROUTE_EVENT = 2'd3;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_BAD     = 2'd1;
   localparam logic [1:0] STAT_UNKNOWN = 2'd2;
   localparam logic [1:0] STAT_RESTART = 2'd3;

   typedef enum logic [1:0] {
      CMD_ONE   = 2'd0,
      CMD_HDR8  = 2'd1,
      CMD_HDR16 = 2'd2
   } cmd_kind_type;

   typedef enum logic [1:0] {
      HALT_RUN     = 2'd0,
      HALT_BAD     = 2'd1,
      HALT_UNKNOWN = 2'd2
   } halt_type;

   // one unit of work for the back end: a single word or a held header
   typedef struct packed {
      cmd_kind_type                kind;
      logic [HEADER_BYTES-1:0][7:0] bytes;
      logic [1:0]                  route;
      logic                        frag_begin;
      logic                        init_complete;
      logic                        frag_complete;
      logic                        box_end;
      logic [31:0]                 box_type;
      logic [1:0]                  status;
   } cmd_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [1:0]  route;
      logic        frag_begin;
      logic        init_complete;
      logic        frag_complete;
      logic        box_end;
      logic [31:0] box_type;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic valid;
   } q_status_type;

endpackage

@@ src/mp4bdr_front.sv @@
// front end: header collection, size checks, box routing and body counting
`timescale 1ns / 1ps

module mp4bdr_front #(
   parameter int unsigned COUNT_WIDTH = 40
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_func,
   input  logic [7:0]                  req_data_byte,
   input  logic [mp4bdr_pkg::MAX_W-1:0] max_box_size,
   input  mp4bdr_pkg::q_status_type    q_status,
   output logic                        push,
   output mp4bdr_pkg::cmd_type         cmd
);
   import mp4bdr_pkg::*;

   localparam logic [63:0] CNT_MASK = (64'd1 << COUNT_WIDTH) - 64'd1;

   logic [HEADER_BYTES-1:0][7:0] store_ff;
   logic [HDR_IDX_W-1:0]         cnt_ff, cnt_in;
   logic [COUNT_WIDTH-1:0]       body_left_ff, body_left_in;
   logic [31:0]                  type_held_ff, type_held_in;
   halt_type                     halt_ff, halt_in;
   logic                         init_done_ff, init_done_in;
   logic                         frag_open_ff, frag_open_in;
   logic [1:0]                   box_route_ff, box_route_in;
   logic                         is_mdat_ff, is_mdat_in;

   logic                         accept;
   logic                         store_wr;
   logic [HEADER_BYTES-1:0][7:0] hdr_bytes;
   logic [31:0]                  size32;
   logic [31:0]                  type32;
   logic [63:0]                  ext64;
   logic                         at_short, at_long, complete;
   logic [4:0]                   hdr_len;
   logic [63:0]                  box_len;
   logic [63:0]                  diff;
   logic                         bad_size;
   logic                         moof;
   logic                         body_end;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   // header as it stands with the current word in place
   always_comb begin
      hdr_bytes         = store_ff;
      hdr_bytes[cnt_ff] = req_data_byte;
   end

   assign size32   = {hdr_bytes[0], hdr_bytes[1], hdr_bytes[2], hdr_bytes[3]};
   assign type32   = {hdr_bytes[4], hdr_bytes[5], hdr_bytes[6], hdr_bytes[7]};
   assign ext64    = {hdr_bytes[8], hdr_bytes[9], hdr_bytes[10], hdr_bytes[11],
                      hdr_bytes[12], hdr_bytes[13], hdr_bytes[14], hdr_bytes[15]};
   assign at_short = (cnt_ff == HDR_IDX_W'(SHORT_HDR - 1));
   assign at_long  = (cnt_ff == HDR_IDX_W'(HEADER_BYTES - 1));
   assign complete = (at_short && (size32 != SIZE_EXTENDED)) || at_long;
   assign hdr_len  = at_long ? 5'(HEADER_BYTES) : 5'(SHORT_HDR);
   assign box_len  = at_long ? ext64 : {32'd0, size32};
   assign diff     = box_len - 64'(hdr_len);
   assign bad_size = (box_len < 64'(hdr_len)) || (box_len > 64'(max_box_size))
                     || ((diff & ~CNT_MASK) != 64'd0);
   assign moof     = (type32 == TYPE_MOOF);
   assign body_end = (body_left_ff == COUNT_WIDTH'(1));

   always_comb begin
      cnt_in       = cnt_ff;
      body_left_in = body_left_ff;
      type_held_in = type_held_ff;
      halt_in      = halt_ff;
      init_done_in = init_done_ff;
      frag_open_in = frag_open_ff;
      box_route_in = box_route_ff;
      is_mdat_in   = is_mdat_ff;
      store_wr     = 1'b0;
      push         = 1'b0;
      cmd          = '0;
      cmd.kind     = CMD_ONE;
      if (accept) begin
         if (req_func == FUNC_RESTART) begin
            cnt_in       = '0;
            body_left_in = '0;
            type_held_in = '0;
            halt_in      = HALT_RUN;
            init_done_in = 1'b0;
            frag_open_in = 1'b0;
            box_route_in = ROUTE_INIT;
            is_mdat_in   = 1'b0;
            push         = 1'b1;
            cmd.route    = ROUTE_EVENT;
            cmd.status   = STAT_RESTART;
         end else if (halt_ff == HALT_RUN) begin
            if (body_left_ff != '0) begin
               body_left_in      = body_left_ff - COUNT_WIDTH'(1);
               push              = 1'b1;
               cmd.bytes[0]      = req_data_byte;
               cmd.route         = box_route_ff;
               cmd.box_type      = type_held_ff;
               cmd.box_end       = body_end;
               cmd.frag_complete = body_end && is_mdat_ff;
               if (body_end && is_mdat_ff) begin
                  frag_open_in = 1'b0;
               end
            end else begin
               store_wr = 1'b1;
               if (!complete) begin
                  cnt_in = cnt_ff + HDR_IDX_W'(1);
               end else begin
                  cnt_in       = '0;
                  type_held_in = type32;
                  push         = 1'b1;
                  cmd.box_type = type32;
                  if (box_len == 64'd0) begin
                     halt_in    = HALT_UNKNOWN;
                     cmd.route  = ROUTE_EVENT;
                     cmd.status = STAT_UNKNOWN;
                  end else if (bad_size) begin
                     halt_in    = HALT_BAD;
                     cmd.route  = ROUTE_EVENT;
                     cmd.status = STAT_BAD;
                  end else begin
                     is_mdat_in = 1'b0;
                     priority if (!init_done_ff && !moof) begin
                        box_route_in = ROUTE_INIT;
                     end else if (moof) begin
                        init_done_in = 1'b1;
                        frag_open_in = 1'b1;
                        box_route_in = ROUTE_FRAG;
                     end else if (frag_open_ff) begin
                        box_route_in = ROUTE_FRAG;
                        is_mdat_in   = (type32 == TYPE_MDAT);
                     end else begin
                        box_route_in = ROUTE_DROP;
                     end
                     body_left_in      = diff[COUNT_WIDTH-1:0];
                     cmd.kind          = at_long ? CMD_HDR16 : CMD_HDR8;
                     cmd.bytes         = hdr_bytes;
                     cmd.route         = box_route_in;
                     cmd.frag_begin    = moof;
                     cmd.init_complete = moof && !init_done_ff;
                     cmd.box_end       = (diff == 64'd0);
                     cmd.frag_complete = (diff == 64'd0) && is_mdat_in;
                     if ((diff == 64'd0) && is_mdat_in) begin
                        frag_open_in = 1'b0;
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         body_left_ff <= '0;
         type_held_ff <= '0;
         halt_ff      <= HALT_RUN;
         init_done_ff <= 1'b0;
         frag_open_ff <= 1'b0;
         box_route_ff <= ROUTE_INIT;
         is_mdat_ff   <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         body_left_ff <= body_left_in;
         type_held_ff <= type_held_in;
         halt_ff      <= halt_in;
         init_done_ff <= init_done_in;
         frag_open_ff <= frag_open_in;
         box_route_ff <= box_route_in;
         is_mdat_ff   <= is_mdat_in;
      end
   end

   // header bytes are payload, only read after being written
   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_ff[cnt_ff] <= req_data_byte;
      end
   end

endmodule

@@ src/mp4bdr_queue.sv @@
// short command queue between the front and back ends
`timescale 1ns / 1ps

module mp4bdr_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  mp4bdr_pkg::cmd_type      push_cmd,
   input  logic                     pop,
   output mp4bdr_pkg::cmd_type      head_cmd,
   output mp4bdr_pkg::q_status_type q_status
);
   import mp4bdr_pkg::*;

   cmd_type            entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;

   assign head_cmd       = entry_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign q_status.valid = (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + Q_CNT_W'(push) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ src/mp4bdr_back.sv @@
// back end: expands commands into result words behind an output register
`timescale 1ns / 1ps

module mp4bdr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  mp4bdr_pkg::cmd_type  head_cmd,
   input  logic                 head_valid,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mp4bdr_pkg::rsp_type  rsp
);
   import mp4bdr_pkg::*;

   cmd_type              cur_ff;
   logic                 busy_ff, busy_in;
   logic [HDR_IDX_W-1:0] idx_ff, idx_in;
   rsp_type              out_ff;
   logic                 out_valid_ff;

   logic [HDR_IDX_W-1:0] last_idx;
   logic                 is_last;
   logic                 out_free;
   logic                 advance;
   rsp_type              next_rsp;

   always_comb begin
      unique case (cur_ff.kind)
         CMD_HDR16: last_idx = HDR_IDX_W'(HEADER_BYTES - 1);
         CMD_HDR8:  last_idx = HDR_IDX_W'(SHORT_HDR - 1);
         default:   last_idx = '0;
      endcase
   end

   assign is_last  = (idx_ff == last_idx);
   assign out_free = !out_valid_ff || !rsp_stall;
   assign advance  = busy_ff && out_free;
   assign pop      = head_valid && (!busy_ff || (advance && is_last));

   always_comb begin
      next_rsp.out_byte      = cur_ff.bytes[idx_ff];
      next_rsp.route         = cur_ff.route;
      next_rsp.frag_begin    = cur_ff.frag_begin && (idx_ff == '0);
      next_rsp.init_complete = cur_ff.init_complete && (idx_ff == '0);
      next_rsp.frag_complete = cur_ff.frag_complete && is_last;
      next_rsp.box_end       = cur_ff.box_end && is_last;
      next_rsp.box_type      = cur_ff.box_type;
      next_rsp.status        = cur_ff.status;
      next_rsp.last          = is_last;
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (pop) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (advance) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + HDR_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (out_free) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head_cmd;
      end
      if (advance) begin
         out_ff <= next_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule

@@ src/mp4_box_deframer_router_unit.sv @@
// top level of the mp4 box deframer and router
//
//  channel | direction | handshake            | contents
//  req     | in        | req_valid/req_stall  | func, one stream byte
//  rsp     | out       | rsp_valid/rsp_stall  | routed word with box flags
//  csr     | in        | csr_write_en         | max_box_size
//
// a body byte, a halt event or a restart gives a single word; a box header
// leaves as 8 or 16 words, one per cycle while rsp_stall is low. header
// bytes are taken one per cycle while req_stall is low and give no word
// until full. reset is synchronous; no clearing pass. a stall on rsp backs up
// the two entry command queue, and req_stall rises once it is full.
`timescale 1ns / 1ps

module mp4_box_deframer_router_unit #(
   parameter int unsigned COUNT_WIDTH = 40
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic [7:0]                   req_data_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_out_byte,
   output logic [1:0]                   rsp_route,
   output logic                         rsp_fragment_begin,
   output logic                         rsp_init_complete,
   output logic                         rsp_fragment_complete,
   output logic                         rsp_box_end,
   output logic [31:0]                  rsp_box_type,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_last,
   input  logic                         csr_write_en,
   input  logic [mp4bdr_pkg::MAX_W-1:0] csr_max_box_size
);
   import mp4bdr_pkg::*;

   logic [MAX_W-1:0] max_size_ff;
   q_status_type     q_status;
   logic             push;
   logic             pop;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   rsp_type          rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff <= MAX_SIZE_RESET;
      end else if (csr_write_en) begin
         max_size_ff <= csr_max_box_size;
      end
   end

   mp4bdr_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_data_byte (req_data_byte),
      .max_box_size  (max_size_ff),
      .q_status      (q_status),
      .push          (push),
      .cmd           (push_cmd)
   );

   mp4bdr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   mp4bdr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .head_valid (q_status.valid),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   assign rsp_out_byte          = rsp.out_byte;
   assign rsp_route             = rsp.route;
   assign rsp_fragment_begin    = rsp.frag_begin;
   assign rsp_init_complete     = rsp.init_complete;
   assign rsp_fragment_complete = rsp.frag_complete;
   assign rsp_box_end           = rsp.box_end;
   assign rsp_box_type          = rsp.box_type;
   assign rsp_status            = rsp.status;
   assign rsp_last              = rsp.last;

endmodule

@@ src/mp4bdr_checker.sv @@
// port level checks on the mp4 box deframer and router, bound to the top level
`timescale 1ns / 1ps

module mp4bdr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_out_byte,
   input logic [1:0]  rsp_route,
   input logic        rsp_fragment_begin,
   input logic        rsp_box_end,
   input logic [31:0] rsp_box_type,
   input logic [1:0]  rsp_status,
   input logic        rsp_last
);
   import mp4bdr_pkg::*;

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_route) && $stable(rsp_status) && $stable(rsp_last))
      else $error("rsp word changed while stalled");

   // events are single words with no box end
   a_event_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_route == ROUTE_EVENT) |-> rsp_last && !rsp_box_end)
      else $error("event word not closing its item");

   // a moof start opens a header flush, so it is never the last word
   a_frag_begin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fragment_begin |-> (rsp_route == ROUTE_FRAG) && !rsp_last
         && (rsp_status == STAT_OK))
      else $error("fragment begin on a bad word");

   // restart events carry no box type
   a_restart_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_RESTART) |-> (rsp_box_type == 32'd0)
         && (rsp_route == ROUTE_EVENT))
      else $error("restart event with stale box type");

endmodule

bind mp4_box_deframer_router_unit mp4bdr_checker u_mp4bdr_checker (.*);

@@ tb/tb_mp4_box_deframer_router_unit.sv @@
// self-checking testbench for the mp4 box deframer and router
`timescale 1ns / 1ps

module tb_mp4_box_deframer_router_unit;
   import mp4bdr_pkg::*;

   localparam int unsigned CNT_W = 40;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 32;
   localparam int PHASES = 5;
   localparam int PHASE_ITEMS = 30;
   localparam logic [31:0] TYPE_FTYP = 32'h66747970;
   localparam logic [31:0] TYPE_MOOV = 32'h6D6F6F76;
   localparam logic [31:0] TYPE_FREE = 32'h66726565;

   typedef enum int {
      SCN_FRAGMENT,
      SCN_ONE_BOX,
      SCN_UNKNOWN_SIZE,
      SCN_BAD_SIZE,
      SCN_HUGE_BOX,
      SCN_NOISE,
      SCN_RESTART
   } scenario_type;

   typedef struct packed {
      logic       func;
      logic [7:0] data;
   } stream_word_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_func = FUNC_BYTE;
   logic [7:0] req_data_byte = 8'd0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_route;
   logic rsp_fragment_begin;
   logic rsp_init_complete;
   logic rsp_fragment_complete;
   logic rsp_box_end;
   logic [31:0] rsp_box_type;
   logic [1:0] rsp_status;
   logic rsp_last;
   logic csr_write_en = 1'b0;
   logic [MAX_W-1:0] csr_max_box_size = MAX_SIZE_RESET;

   mp4_box_deframer_router_unit #(
      .COUNT_WIDTH(CNT_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_route(rsp_route),
      .rsp_fragment_begin(rsp_fragment_begin),
      .rsp_init_complete(rsp_init_complete),
      .rsp_fragment_complete(rsp_fragment_complete),
      .rsp_box_end(rsp_box_end),
      .rsp_box_type(rsp_box_type),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last),
      .csr_write_en(csr_write_en),
      .csr_max_box_size(csr_max_box_size)
   );

   stream_word_type byte_feed[$];
   rsp_type routed_words[$];
   int fed_items = 0;
   int errors = 0;
   int quiet_cycles = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   // predictor copy of the parser state
   logic [7:0] hdr_held[HEADER_BYTES];
   int hdr_count = 0;
   logic [31:0] held_type = '0;
   logic [CNT_W-1:0] body_rem = '0;
   halt_type halt_state = HALT_RUN;
   logic init_seen = 1'b0;
   logic frag_open = 1'b0;
   logic [1:0] cur_route = ROUTE_INIT;
   logic cur_mdat = 1'b0;
   logic [MAX_W-1:0] box_cap = MAX_SIZE_RESET;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic expect_word(input rsp_type w);
      routed_words.insert(routed_words.size(), w);
   endtask

   task automatic route_stream_word(input logic func, input logic [7:0] b);
      rsp_type w;
      logic [63:0] size;
      int hlen;
      int i;
      logic is_moof;
      logic first_moof;
      w = '0;
      if (func == FUNC_RESTART) begin
         hdr_count = 0;
         held_type = '0;
         body_rem = '0;
         halt_state = HALT_RUN;
         init_seen = 1'b0;
         frag_open = 1'b0;
         cur_route = ROUTE_INIT;
         cur_mdat = 1'b0;
         w.route = ROUTE_EVENT;
         w.status = STAT_RESTART;
         w.last = 1'b1;
         expect_word(w);
         return;
      end
      if (halt_state != HALT_RUN) return;

      if (body_rem != 0) begin
         body_rem = body_rem - CNT_W'(1);
         w.out_byte = b;
         w.route = cur_route;
         w.box_end = (body_rem == 0);
         w.frag_complete = w.box_end && cur_mdat;
         if (w.frag_complete) frag_open = 1'b0;
         w.box_type = held_type;
         w.status = STAT_OK;
         w.last = 1'b1;
         expect_word(w);
         return;
      end

      if (hdr_count >= HEADER_BYTES) hdr_count = 0;
      hdr_held[hdr_count] = b;
      hdr_count++;
      if (hdr_count < SHORT_HDR) return;
      if ({hdr_held[0], hdr_held[1], hdr_held[2], hdr_held[3]} == SIZE_EXTENDED) begin
         if (hdr_count < HEADER_BYTES) return;
         hlen = int'(HEADER_BYTES);
         size = {hdr_held[8], hdr_held[9], hdr_held[10], hdr_held[11],
                 hdr_held[12], hdr_held[13], hdr_held[14], hdr_held[15]};
      end else begin
         hlen = int'(SHORT_HDR);
         size = {32'd0, hdr_held[0], hdr_held[1], hdr_held[2], hdr_held[3]};
      end
      held_type = {hdr_held[4], hdr_held[5], hdr_held[6], hdr_held[7]};
      hdr_count = 0;

      if (size == 0 || size < 64'(hlen) || size > 64'(box_cap) ||
          ((size - 64'(hlen)) >> CNT_W) != 0) begin
         halt_state = (size == 0) ? HALT_UNKNOWN : HALT_BAD;
         w.route = ROUTE_EVENT;
         w.box_type = held_type;
         w.status = (size == 0) ? STAT_UNKNOWN : STAT_BAD;
         w.last = 1'b1;
         expect_word(w);
         return;
      end

      is_moof = (held_type == TYPE_MOOF);
      first_moof = is_moof && !init_seen;
      cur_mdat = 1'b0;
      if (!init_seen && !is_moof) begin
         cur_route = ROUTE_INIT;
      end else if (is_moof) begin
         init_seen = 1'b1;
         frag_open = 1'b1;
         cur_route = ROUTE_FRAG;
      end else if (frag_open) begin
         cur_route = ROUTE_FRAG;
         cur_mdat = (held_type == TYPE_MDAT);
      end else begin
         cur_route = ROUTE_DROP;
      end
      body_rem = CNT_W'(size - 64'(hlen));

      for (i = 0; i < hlen; i++) begin
         w = '0;
         w.out_byte = hdr_held[i];
         w.route = cur_route;
         w.frag_begin = (i == 0) && is_moof;
         w.init_complete = (i == 0) && first_moof;
         w.box_end = (i == hlen - 1) && (body_rem == 0);
         w.frag_complete = w.box_end && cur_mdat;
         w.box_type = held_type;
         w.status = STAT_OK;
         w.last = (i == hlen - 1);
         expect_word(w);
      end
      // a header-only mdat closes its fragment on the last header word
      if (body_rem == 0 && cur_mdat) frag_open = 1'b0;
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      end
   endtask

   // driver
   always @(posedge clock) begin
      logic taken;
      stream_word_type nxt;
      taken = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
         req_func <= FUNC_BYTE;
         req_data_byte <= 8'd0;
      end else begin
         if (taken) route_stream_word(req_func, req_data_byte);
         if (taken || !req_valid) begin
            if (byte_feed.size() != 0 && $urandom_range(99) >= idle_pct) begin
               nxt = byte_feed.pop_front();
               req_valid <= 1'b1;
               req_func <= nxt.func;
               req_data_byte <= nxt.data;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (routed_words.size() == 0) begin
               errors++;
               $display("%0t: word with no expectation, expected none %s %0h route %0d",
                        $time, "actual byte", rsp_out_byte, rsp_route);
            end else begin
               want = routed_words.pop_front();
               check_field("out_byte", 64'(want.out_byte), 64'(rsp_out_byte));
               check_field("route", 64'(want.route), 64'(rsp_route));
               check_field("fragment_begin", 64'(want.frag_begin),
                           64'(rsp_fragment_begin));
               check_field("init_complete", 64'(want.init_complete),
                           64'(rsp_init_complete));
               check_field("fragment_complete", 64'(want.frag_complete),
                           64'(rsp_fragment_complete));
               check_field("box_end", 64'(want.box_end), 64'(rsp_box_end));
               check_field("box_type", 64'(want.box_type), 64'(rsp_box_type));
               check_field("status", 64'(want.status), 64'(rsp_status));
               check_field("last", 64'(want.last), 64'(rsp_last));
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_word(input stream_word_type sw);
      byte_feed.insert(byte_feed.size(), sw);
      fed_items++;
   endtask

   task automatic feed_byte(input logic [7:0] b);
      stream_word_type sw;
      sw.func = FUNC_BYTE;
      sw.data = b;
      queue_word(sw);
   endtask

   task automatic feed_restart();
      stream_word_type sw;
      sw.func = FUNC_RESTART;
      sw.data = 8'($urandom);
      queue_word(sw);
   endtask

   task automatic feed_box(input logic [31:0] btype, input logic [63:0] bsize,
                           input bit ext, input int body_n);
      logic [31:0] size_field;
      int i;
      size_field = ext ? SIZE_EXTENDED : bsize[31:0];
      for (i = 0; i < 4; i++) feed_byte(size_field[31-8*i -: 8]);
      for (i = 0; i < 4; i++) feed_byte(btype[31-8*i -: 8]);
      if (ext) for (i = 0; i < 8; i++) feed_byte(bsize[63-8*i -: 8]);
      for (i = 0; i < body_n; i++) feed_byte(8'($urandom));
   endtask

   // well-formed box whose size stays within the current maximum
   task automatic feed_fitting_box(input logic [31:0] btype);
      bit ext;
      int hlen;
      int body_n;
      ext = ($urandom_range(4) == 0);
      hlen = ext ? int'(HEADER_BYTES) : int'(SHORT_HDR);
      body_n = $urandom_range(0, 12);
      if (64'(hlen + body_n) > 64'(box_cap)) body_n = int'(box_cap) - hlen;
      feed_box(btype, 64'(hlen + body_n), ext, body_n);
   endtask

   task automatic feed_scenario();
      scenario_type scn;
      int pick;
      int i;
      bit ext;
      int hlen;
      logic [63:0] sz;
      logic [31:0] btype;
      pick = $urandom_range(99);
      ext = ($urandom_range(3) == 0);
      hlen = ext ? int'(HEADER_BYTES) : int'(SHORT_HDR);
      case ($urandom_range(4))
         0: btype = TYPE_MOOF;
         1: btype = TYPE_MDAT;
         2: btype = TYPE_FTYP;
         3: btype = TYPE_MOOV;
         default: btype = $urandom;
      endcase
      if (pick < 35) scn = SCN_FRAGMENT;
      else if (pick < 58) scn = SCN_ONE_BOX;
      else if (pick < 66) scn = SCN_UNKNOWN_SIZE;
      else if (pick < 77) scn = SCN_BAD_SIZE;
      else if (pick < 85) scn = SCN_HUGE_BOX;
      else if (pick < 92) scn = SCN_NOISE;
      else scn = SCN_RESTART;

      case (scn)
         SCN_FRAGMENT: begin
            feed_fitting_box(TYPE_MOOF);
            if ($urandom_range(1)) feed_fitting_box(btype);
            feed_fitting_box(TYPE_MDAT);
         end
         SCN_ONE_BOX: feed_fitting_box(btype);
         SCN_UNKNOWN_SIZE: begin
            feed_box(btype, 64'd0, ext, 0);
            for (i = $urandom_range(0, 2); i > 0; i--) feed_byte(8'($urandom));
            feed_restart();
         end
         SCN_BAD_SIZE: begin
            case ($urandom_range(3))
               0: begin
                  ext = 1'b0;
                  sz = 64'($urandom_range(2, 7));
               end
               1: begin
                  ext = 1'b1;
                  sz = 64'($urandom_range(1, 15));
               end
               2: begin
                  sz = 64'(box_cap) + 64'd1 + 64'($urandom_range(0, 255));
                  if (sz > 64'hFFFF_FFFF) ext = 1'b1;
               end
               default: sz = ext ? {$urandom, $urandom} : 64'($urandom);
            endcase
            feed_box(btype, sz, ext, 0);
            for (i = $urandom_range(0, 2); i > 0; i--) feed_byte(8'($urandom));
            feed_restart();
         end
         SCN_HUGE_BOX: begin
            // sizes up to the current maximum: at most ten body words are sent, then a restart
            if ($urandom_range(1)) sz = 64'(box_cap);
            else sz = 64'(hlen) + {$urandom, $urandom} % (64'(box_cap) - 64'(hlen) + 64'd1);
            if (sz > 64'hFFFF_FFFF) ext = 1'b1;
            feed_box(btype, sz, ext, $urandom_range(0, 10));
            feed_restart();
         end
         SCN_NOISE: begin
            for (i = $urandom_range(1, 10); i > 0; i--) feed_byte(8'($urandom));
            feed_restart();
         end
         default: feed_restart();
      endcase
   endtask

   // wait for the stream to go idle with nothing left to arrive
   task automatic drain_stream();
      while (byte_feed.size() != 0 || req_valid || routed_words.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_max_size(input logic [MAX_W-1:0] v);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_max_box_size <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      box_cap = v;
   endtask

   initial begin
      logic [MAX_W-1:0] caps[PHASES];
      int idles[PHASES];
      int stalls[PHASES];
      int p;
      caps = '{MAX_SIZE_RESET, 41'h100_0000_0000, 41'd16, 41'd64, 41'd1024};
      idles = '{0, 83, 0, 28, 0};
      stalls = '{0, 0, 83, 28, 0};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // header-only first moof, header-only mdat closing it, then a zero size
      // halt, one ignored word and a restart
      feed_box(TYPE_MOOF, 64'd8, 1'b0, 0);
      feed_box(TYPE_MDAT, 64'd8, 1'b0, 0);
      feed_box(TYPE_FREE, 64'd0, 1'b0, 0);
      feed_byte(8'hFF);
      feed_restart();

      for (p = 0; p < PHASES; p++) begin
         if (p != 0) write_max_size(caps[p]);
         @(negedge clock);
         idle_pct = idles[p];
         stall_pct = stalls[p];
         while (fed_items < 26 + (p + 1) * PHASE_ITEMS) feed_scenario();
         drain_stream();
      end

      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ sim.f @@
src/mp4bdr_pkg.sv
src/mp4bdr_front.sv
src/mp4bdr_queue.sv
src/mp4bdr_back.sv
src/mp4_box_deframer_router_unit.sv
src/mp4bdr_checker.sv
tb/tb_mp4_box_deframer_router_unit.sv
